// File: design/quote_aware_word_splitter_defines.svh
// Assertion macros used by the checker file of the word splitter.
`ifndef QUOTE_AWARE_WORD_SPLITTER_DEFINES_SVH
`define QUOTE_AWARE_WORD_SPLITTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is low.
`define QAWS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while reset is low.
`define QAWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/qaws_pkg.sv
// Types, constants and per-byte tokenizing functions of the word splitter.
package qaws_pkg;

    localparam int unsigned MaxWords = 128;
    localparam int unsigned WcW      = $clog2(MaxWords + 2);
    localparam int unsigned IdxW     = 7;

    localparam logic [WcW-1:0] MaxWordsW = WcW'(MaxWords);
    localparam logic [WcW-1:0] DropMark  = WcW'(MaxWords + 1);

    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_EOW  = 2'd1,
        KIND_EOL  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind           kind;
        logic [7:0]      ch;
        logic [IdxW-1:0] idx;
        logic            ovf;
    } t_res;

    typedef struct packed {
        logic           in_single;
        logic           in_double;
        logic           esc;
        logic           dq_bs;
        logic           word_open;
        logic [WcW-1:0] word_count;
        logic           ovf_seen;
    } t_state;

    typedef struct packed {
        t_state      st;
        t_res [3:0]  res;
        logic [2:0]  n;
    } t_work;

    function automatic t_work f_emit(t_work w, t_kind k, logic [7:0] c,
                                     logic [IdxW-1:0] idx, logic ovf);
        t_work r;
        r = w;
        r.res[r.n[1:0]].kind = k;
        r.res[r.n[1:0]].ch   = c;
        r.res[r.n[1:0]].idx  = idx;
        r.res[r.n[1:0]].ovf  = ovf;
        r.n = r.n + 3'd1;
        return r;
    endfunction

    function automatic logic [IdxW-1:0] f_idx(logic [WcW-1:0] cnt);
        logic [WcW-1:0] m1;
        m1 = cnt - WcW'(1);
        return m1[IdxW-1:0];
    endfunction

    function automatic t_work f_put(t_work w, logic [7:0] c);
        t_work r;
        r = w;
        if (!r.st.word_open) begin
            r.st.word_open = 1'b1;
            if (r.st.word_count < MaxWordsW) begin
                r.st.word_count = r.st.word_count + WcW'(1);
            end else begin
                r.st.word_count = DropMark;
                r.st.ovf_seen   = 1'b1;
            end
        end
        if (r.st.word_count <= MaxWordsW) begin
            r = f_emit(r, KIND_CHAR, c, f_idx(r.st.word_count), 1'b0);
        end
        return r;
    endfunction

    function automatic t_work f_end_word(t_work w);
        t_work r;
        r = w;
        if (r.st.word_open) begin
            r.st.word_open = 1'b0;
            if (r.st.word_count != '0 && r.st.word_count <= MaxWordsW) begin
                r = f_emit(r, KIND_EOW, 8'h00, f_idx(r.st.word_count), 1'b0);
            end
        end
        return r;
    endfunction

    // All results and the next state for one byte of the line.
    function automatic t_work f_step(t_state s, logic tab_sep, logic [7:0] c, logic last);
        t_work r;
        r     = '0;
        r.st  = s;
        if (r.st.esc) begin
            r.st.esc = 1'b0;
            r = f_put(r, c);
        end else if (r.st.dq_bs) begin
            r.st.dq_bs = 1'b0;
            if (c != C_BSLASH && c != C_DQUOTE) begin
                r = f_put(r, C_BSLASH);
            end
            r = f_put(r, c);
        end else if (r.st.in_single) begin
            if (c == C_SQUOTE) begin
                r.st.in_single = 1'b0;
            end else begin
                r = f_put(r, c);
            end
        end else if (r.st.in_double) begin
            if (c == C_DQUOTE) begin
                r.st.in_double = 1'b0;
            end else if (c == C_BSLASH) begin
                r.st.dq_bs = 1'b1;
            end else begin
                r = f_put(r, c);
            end
        end else if (c == C_SPACE || (c == C_TAB && tab_sep)) begin
            r = f_end_word(r);
        end else if (c == C_SQUOTE) begin
            r.st.in_single = 1'b1;
        end else if (c == C_DQUOTE) begin
            r.st.in_double = 1'b1;
        end else if (c == C_BSLASH) begin
            r.st.esc = 1'b1;
        end else begin
            r = f_put(r, c);
        end

        if (last) begin
            // A backslash left open inside double quotes is kept literally.
            if (r.st.dq_bs) begin
                r = f_put(r, C_BSLASH);
            end
            r    = f_end_word(r);
            r    = f_emit(r, KIND_EOL, 8'h00, '0, r.st.ovf_seen);
            r.st = '0;
        end
        return r;
    endfunction

endpackage

// File: design/quote_aware_word_splitter.sv
// A byte passes the input register and then the result list before its first result shows.
// One byte per cycle while each byte gives at most one result and m_axis_tready is high;
// a byte that gives several results (up to 4) holds the result list until all have left.
// The input register takes a new byte while the result list is still draining.
// Reset is synchronous, active low: quote state, word count and tab setting clear.
module quote_aware_word_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] char_out, [14:8] word_index, [15] overflow
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;
    logic               r_tab;
    qaws_pkg::t_state   r_state;
    qaws_pkg::t_res [3:0] r_res;
    logic [2:0]         r_cnt;
    logic [1:0]         r_pos;

    qaws_pkg::t_work    w_step;
    qaws_pkg::t_res     w_cur;
    logic               w_at_end;
    logic               w_out_fire;
    logic               w_free;
    logic               w_load;

    assign w_step     = qaws_pkg::f_step(r_state, r_tab, r_in_byte, r_in_last);
    assign w_cur      = r_res[r_pos];
    assign w_at_end   = ({1'b0, r_pos} == (r_cnt - 3'd1));
    assign w_out_fire = (r_cnt != 3'd0) && m_axis_tready;
    // The list can take new results when it is empty or its final entry leaves now.
    assign w_free     = (r_cnt == 3'd0) || (w_out_fire && w_at_end);
    assign w_load     = r_in_valid && w_free;

    assign s_axis_tready = !r_in_valid || w_load;
    assign m_axis_tvalid = (r_cnt != 3'd0);
    assign m_axis_tuser  = w_cur.kind;
    assign m_axis_tdata  = {w_cur.ovf, w_cur.idx, w_cur.ch};
    assign m_axis_tlast  = w_at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_tab      <= 1'b0;
            r_state    <= '0;
            r_cnt      <= 3'd0;
            r_pos      <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_tab <= i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_load) begin
                r_in_valid <= 1'b0;
            end
            if (w_load) begin
                r_state <= w_step.st;
                r_cnt   <= w_step.n;
                r_pos   <= 2'd0;
            end else if (w_out_fire) begin
                if (w_at_end) begin
                    r_cnt <= 3'd0;
                    r_pos <= 2'd0;
                end else begin
                    r_pos <= r_pos + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (w_load) begin
            r_res <= w_step.res;
        end
    end

endmodule

// File: design/qaws_checker.sv
// Port-level checker for the word splitter and its bind to the top level.
`include "quote_aware_word_splitter_defines.svh"

module qaws_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_cfg_wdata,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result transfer keeps its whole payload.
    `QAWS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

    // End of line closes the run of its byte and carries word index zero.
    `QAWS_ASSERT_IMPL(a_eol_shape, m_axis_tvalid && m_axis_tuser == qaws_pkg::KIND_EOL, m_axis_tlast && m_axis_tdata[14:8] == 7'd0, "bad end of line")

    // Only word characters carry a character value.
    `QAWS_ASSERT_IMPL(a_char_zero, m_axis_tvalid && m_axis_tuser != qaws_pkg::KIND_CHAR, m_axis_tdata[7:0] == 8'd0, "nonzero char on marker")

    // The overflow flag appears on end of line only.
    `QAWS_ASSERT_IMPL(a_ovf_eol, m_axis_tvalid && m_axis_tuser != qaws_pkg::KIND_EOL, !m_axis_tdata[15], "overflow off end of line")

endmodule

bind quote_aware_word_splitter qaws_checker u_qaws_checker (.*);

// File: tb/tb_quote_aware_word_splitter.sv
// Self-checking testbench of the quote-aware word splitter, with its own token predictor.
module tb_quote_aware_word_splitter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HoldAt     = 200;
    localparam int HoldCycles = 300;
    localparam int SettleCyc  = 8;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_line_byte;

    typedef struct {
        qaws_pkg::t_kind kind;
        logic [7:0]      ch;
        logic [6:0]      idx;
        logic            ovf;
        logic            run_last;
    } t_token;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] byte_in
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [7:0] char_out, [14:8] word_index, [15] overflow
    logic [1:0]  m_axis_tuser;          // [1:0] kind
    logic        m_axis_tlast;

    quote_aware_word_splitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    t_line_byte line_bytes[$];
    t_line_byte staging[$];
    t_token     expected_tokens[$];
    t_token     step_tokens[$];

    int   errors = 0;
    int   bytes_taken = 0;
    logic in_fire = 1'b0;
    logic no_idle = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    // Predictor state, cleared by reset; all but the tab setting also clear at every line end.
    logic       tab_sep = 1'b0;
    logic       sq_open = 1'b0;
    logic       dq_open = 1'b0;
    logic       esc_next = 1'b0;
    logic       dq_bs_next = 1'b0;
    logic       in_word = 1'b0;
    logic [7:0] words_seen = 8'd0;
    logic       words_dropped = 1'b0;

    function automatic void clear_line_state();
        sq_open       = 1'b0;
        dq_open       = 1'b0;
        esc_next      = 1'b0;
        dq_bs_next    = 1'b0;
        in_word       = 1'b0;
        words_seen    = 8'd0;
        words_dropped = 1'b0;
    endfunction

    function automatic void add_token(qaws_pkg::t_kind k, logic [7:0] c, logic [6:0] idx,
                                      logic ovf);
        t_token t;
        t.kind     = k;
        t.ch       = c;
        t.idx      = idx;
        t.ovf      = ovf;
        t.run_last = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void put_char(logic [7:0] c);
        if (!in_word) begin
            in_word = 1'b1;
            if (words_seen < qaws_pkg::MaxWords) begin
                words_seen = words_seen + 8'd1;
            end else begin
                // The word is past the limit: it is counted as dropped and stays silent.
                words_seen    = 8'(qaws_pkg::MaxWords + 1);
                words_dropped = 1'b1;
            end
        end
        if (words_seen <= qaws_pkg::MaxWords) begin
            add_token(qaws_pkg::KIND_CHAR, c, 7'(words_seen - 8'd1), 1'b0);
        end
    endfunction

    function automatic void close_word();
        if (in_word) begin
            in_word = 1'b0;
            if (words_seen != 8'd0 && words_seen <= qaws_pkg::MaxWords) begin
                add_token(qaws_pkg::KIND_EOW, 8'h00, 7'(words_seen - 8'd1), 1'b0);
            end
        end
    endfunction

    function automatic void tokenize_byte(logic [7:0] c, logic last);
        step_tokens.delete();
        if (esc_next) begin
            esc_next = 1'b0;
            put_char(c);
        end else if (dq_bs_next) begin
            dq_bs_next = 1'b0;
            if (c != qaws_pkg::C_BSLASH && c != qaws_pkg::C_DQUOTE) begin
                put_char(qaws_pkg::C_BSLASH);
            end
            put_char(c);
        end else if (sq_open) begin
            if (c == qaws_pkg::C_SQUOTE) begin
                sq_open = 1'b0;
            end else begin
                put_char(c);
            end
        end else if (dq_open) begin
            if (c == qaws_pkg::C_DQUOTE) begin
                dq_open = 1'b0;
            end else if (c == qaws_pkg::C_BSLASH) begin
                dq_bs_next = 1'b1;
            end else begin
                put_char(c);
            end
        end else if (c == qaws_pkg::C_SPACE || (c == qaws_pkg::C_TAB && tab_sep)) begin
            close_word();
        end else if (c == qaws_pkg::C_SQUOTE) begin
            sq_open = 1'b1;
        end else if (c == qaws_pkg::C_DQUOTE) begin
            dq_open = 1'b1;
        end else if (c == qaws_pkg::C_BSLASH) begin
            esc_next = 1'b1;
        end else begin
            put_char(c);
        end

        if (last) begin
            if (dq_bs_next) begin
                put_char(qaws_pkg::C_BSLASH);
            end
            close_word();
            add_token(qaws_pkg::KIND_EOL, 8'h00, 7'd0, words_dropped);
            clear_line_state();
        end

        if (step_tokens.size() > 0) begin
            step_tokens[step_tokens.size() - 1].run_last = 1'b1;
        end
        foreach (step_tokens[i]) begin
            expected_tokens.push_back(step_tokens[i]);
        end
    endfunction

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            errors++;
        end
    endfunction

    // Monitor and predictor: both handshakes and config writes are sampled at the rising edge.
    always @(posedge i_clk) begin
        t_token t;
        if (!i_rst_n) begin
            tab_sep = 1'b0;
            clear_line_state();
            in_fire = 1'b0;
        end else begin
            if (i_cfg_we) begin
                tab_sep = i_cfg_wdata;
            end
            in_fire = s_axis_tvalid && s_axis_tready;
            if (in_fire) begin
                bytes_taken++;
                tokenize_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_tokens.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, %s %h %0d",
                             $time, "actual tdata and tuser", m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    t = expected_tokens.pop_front();
                    check_field("kind", int'(t.kind), int'(m_axis_tuser));
                    check_field("char_out", int'(t.ch), int'(m_axis_tdata[7:0]));
                    check_field("word_index", int'(t.idx), int'(m_axis_tdata[14:8]));
                    check_field("overflow", int'(t.ovf), int'(m_axis_tdata[15]));
                    check_field("run_last", int'(t.run_last), int'(m_axis_tlast));
                end
            end
        end
    end

    // Byte driver: holds an offered byte until its transfer, then maybe idles.
    always @(negedge i_clk) begin
        t_line_byte b;
        if (!s_axis_tvalid || in_fire) begin
            if (line_bytes.size() > 0 && (no_idle || $urandom_range(0, 99) >= 38)) begin
                b = line_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= b.data;
                s_axis_tlast  <= b.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off once enough bytes have gone in.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && bytes_taken >= HoldAt) begin
            hold_done = 1'b1;
            hold_left = HoldCycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 38);
        end
    end

    task automatic stage_byte(logic [7:0] b);
        t_line_byte lb;
        lb.data = b;
        lb.last = 1'b0;
        staging.push_back(lb);
    endtask

    task automatic stage_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            stage_byte(s[i]);
        end
    endtask

    // Marks the final staged byte as the line end and hands the line to the driver.
    task automatic commit_line();
        if (staging.size() > 0) begin
            staging[staging.size() - 1].last = 1'b1;
        end
        foreach (staging[i]) begin
            line_bytes.push_back(staging[i]);
        end
        staging.delete();
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do begin
            b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h61, 8'h7A))
                                            : 8'($urandom_range(0, 255));
        end while (b == qaws_pkg::C_SPACE || b == qaws_pkg::C_TAB ||
                   b == qaws_pkg::C_SQUOTE || b == qaws_pkg::C_DQUOTE ||
                   b == qaws_pkg::C_BSLASH);
        return b;
    endfunction

    // Mostly well-formed words built of plain, quoted and escaped pieces, with some noise.
    task automatic stage_random_line();
        int nw;
        int np;
        int n;
        logic [7:0] b;
        nw = $urandom_range(1, 4);
        if ($urandom_range(0, 5) == 0) begin
            stage_byte(qaws_pkg::C_SPACE);
        end
        for (int w = 0; w < nw; w++) begin
            np = $urandom_range(1, 3);
            for (int p = 0; p < np; p++) begin
                case ($urandom_range(0, 5))
                    0, 1: begin
                        n = $urandom_range(1, 3);
                        for (int i = 0; i < n; i++) stage_byte(plain_char());
                    end
                    2: begin
                        stage_byte(qaws_pkg::C_SQUOTE);
                        n = $urandom_range(0, 3);
                        for (int i = 0; i < n; i++) begin
                            do b = 8'($urandom_range(0, 255)); while (b == qaws_pkg::C_SQUOTE);
                            stage_byte(b);
                        end
                        if ($urandom_range(0, 7) != 0) stage_byte(qaws_pkg::C_SQUOTE);
                    end
                    3: begin
                        stage_byte(qaws_pkg::C_DQUOTE);
                        n = $urandom_range(0, 3);
                        for (int i = 0; i < n; i++) begin
                            case ($urandom_range(0, 3))
                                0: stage_byte(plain_char());
                                1: begin
                                    stage_byte(qaws_pkg::C_BSLASH);
                                    stage_byte(qaws_pkg::C_BSLASH);
                                end
                                2: begin
                                    stage_byte(qaws_pkg::C_BSLASH);
                                    stage_byte(qaws_pkg::C_DQUOTE);
                                end
                                default: begin
                                    stage_byte(qaws_pkg::C_BSLASH);
                                    stage_byte(8'($urandom_range(0, 255)));
                                end
                            endcase
                        end
                        if ($urandom_range(0, 7) != 0) stage_byte(qaws_pkg::C_DQUOTE);
                    end
                    4: begin
                        stage_byte(qaws_pkg::C_BSLASH);
                        stage_byte(8'($urandom_range(0, 255)));
                    end
                    default: stage_byte(8'($urandom_range(0, 255)));
                endcase
            end
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++) begin
                stage_byte(($urandom_range(0, 1) == 0) ? qaws_pkg::C_SPACE : qaws_pkg::C_TAB);
            end
        end
        case ($urandom_range(0, 5))
            0: stage_byte(qaws_pkg::C_BSLASH);
            1: begin
                stage_byte(qaws_pkg::C_DQUOTE);
                stage_byte(qaws_pkg::C_BSLASH);
            end
            default: stage_byte(plain_char());
        endcase
        commit_line();
    endtask

    task automatic stage_random_phase(int n_bytes);
        int start;
        start = line_bytes.size();
        while (line_bytes.size() - start < n_bytes) begin
            stage_random_line();
        end
    endtask

    // Waits until every byte has gone in and every result has come out, then settles.
    task automatic wait_drained();
        while (line_bytes.size() != 0 || s_axis_tvalid || expected_tokens.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SettleCyc) @(negedge i_clk);
    endtask

    task automatic write_tab_sep(logic v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_tab_sep(1'b0);

        // Byte extremes, a quoted piece with a space, and empty quotes closing the line.
        stage_byte(8'h00);
        stage_byte(8'hFF);
        stage_text(" 'a b'\"\"");
        commit_line();
        // Escapes inside double quotes, an escaped space, a tab as a character and
        // a trailing backslash outside quotes that is discarded.
        stage_text("x\"\\\\\\\"\\q\"\\ \t\\");
        commit_line();
        // Unclosed double quote with a backslash still pending at the line end.
        stage_text("\"a\\");
        commit_line();
        wait_drained();

        // No idling on either side during this phase.
        no_idle = 1'b1;
        write_tab_sep(1'b1);
        stage_random_phase(24);
        wait_drained();
        no_idle = 1'b0;

        // More words than the limit: the last two are dropped and flagged.
        write_tab_sep(1'b0);
        for (int w = 0; w < qaws_pkg::MaxWords + 2; w++) begin
            stage_byte(plain_char());
            if (w != qaws_pkg::MaxWords + 1) stage_byte(qaws_pkg::C_SPACE);
        end
        commit_line();
        stage_random_phase(8);
        wait_drained();

        write_tab_sep(1'b1);
        stage_random_phase(8);
        wait_drained();

        repeat (10) @(negedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
